// ===== hw/rtl/heap_segment_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// heap segment allocator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef HEAP_SEGMENT_ALLOCATOR_ASSERT_SVH
`define HEAP_SEGMENT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define HSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heap allocator check failed");

// next-cycle implication, sampled on clk, off during reset
`define HSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heap allocator check failed");

`endif

// ===== hw/rtl/hsa_pkg.sv =====
// ----------------------------------------------------------------------------
// hsa_pkg
// types and constants shared by the heap segment allocator modules
// ----------------------------------------------------------------------------
package hsa_pkg;

  localparam int ADDR_W = 17;

  // reset values of the configuration registers
  localparam int RST_HEAP_BYTES  = 65536;
  localparam int RST_SMALL_LIMIT = 64;
  localparam int RST_LARGE_LIMIT = 256;

  // sizes are kept in multiples of the grain; a split needs header plus min payload
  localparam int GRAIN     = 8;
  localparam int SPLIT_MIN = 8;

  typedef enum logic [1:0] {
    REG_HEAP_BYTES  = 2'd0,
    REG_SMALL_LIMIT = 2'd1,
    REG_LARGE_LIMIT = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_FREE    = 2'd1,
    FN_REALLOC = 2'd2,
    FN_REINIT  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADADDR = 2'd2,
    ST_NOINIT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FIT_FIRST,
    FIT_BEST,
    FIT_NEXT
  } policy_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REINIT,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SPLIT_WR,
    S_MARK1,
    S_MARK2,
    S_MERGE,
    S_TOTAL,
    S_OUT
  } hsa_state_t;

  // one row of the block table
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic              free;
  } entry_t;

  // what the evaluation unit says about one block
  typedef struct packed {
    logic [ADDR_W-1:0] size;
    logic [ADDR_W:0]   pay;
    logic              fits;
    logic              ge_r;
  } blk_info_t;

endpackage

// ===== hw/rtl/hsa_table.sv =====
// ----------------------------------------------------------------------------
// hsa_table
// block table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module hsa_table import hsa_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/hsa_blk_eval.sv =====
// ----------------------------------------------------------------------------
// hsa_blk_eval
// shared block unit: payload size, fit test and rover position of one block
// ----------------------------------------------------------------------------
module hsa_blk_eval import hsa_pkg::*; #(
  parameter int HEADER_BYTES = 24
) (
  input  entry_t            cur,
  input  logic [ADDR_W-1:0] next_start,
  input  logic              last,
  input  logic [ADDR_W-1:0] rover,
  input  logic [ADDR_W:0]   rsize,
  output blk_info_t         info
);

  localparam logic [ADDR_W:0] HDR = (ADDR_W+1)'(HEADER_BYTES);

  logic [ADDR_W:0] lo;
  logic [ADDR_W:0] hi;

  always_comb begin
    lo        = {1'b0, cur.start} + HDR;
    hi        = {1'b0, next_start};
    info.pay  = lo;
    info.size = (hi > lo) ? ADDR_W'(hi - lo) : '0;
    info.fits = cur.free && ({1'b0, info.size} >= rsize);
    info.ge_r = last || (next_start > rover);
  end

endmodule

// ===== hw/rtl/heap_segment_allocator.sv =====
// ----------------------------------------------------------------------------
// heap_segment_allocator
// heap metadata manager over an address-ordered block table, one sequencer
// ----------------------------------------------------------------------------
// one item at a time: table walks of one entry per cycle through the read port
// alloc without split: search walk, decision, a mark write, totals walk and response;
// a split adds a read and a write per entry shifted plus the split write, free adds
// a compaction pass over the table; cmd_ready is high only when idle
// rst clears control and loads register defaults, then the clear state writes
// table entry 0 before the first command beat is taken
module heap_segment_allocator import hsa_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 24
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command channel
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [1:0]  func,
  input  logic [16:0] req_size,
  input  logic [16:0] payload_addr,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [1:0]  status,
  output logic [16:0] result_addr,
  output logic [16:0] used_bytes,
  output logic [16:0] free_bytes
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int SW = $clog2(MAX_BLOCKS + 2);

  localparam logic [CW-1:0]   CNT_MAX  = CW'(MAX_BLOCKS);
  localparam logic [ADDR_W:0] HDR      = (ADDR_W+1)'(HEADER_BYTES);
  localparam logic [ADDR_W:0] HEAP_CAP = (HEAP_BYTES > 131071) ? 18'd131071
                                                               : 18'(HEAP_BYTES);
  localparam logic [ADDR_W-1:0] RST_LEN = (RST_HEAP_BYTES < HEAP_BYTES)
                                          ? ADDR_W'(RST_HEAP_BYTES)
                                          : ADDR_W'(HEAP_BYTES);
  localparam logic [CW-1:0] RST_CNT = (RST_HEAP_BYTES > HEADER_BYTES &&
                                       HEAP_BYTES > HEADER_BYTES) ? CW'(1) : CW'(0);

  // configuration registers
  logic [ADDR_W-1:0] heap_bytes;
  logic [ADDR_W-1:0] small_limit;
  logic [ADDR_W-1:0] large_limit;
  logic              cfg_we;
  reg_idx_t          cfg_idx;

  // sequencer and table state
  hsa_state_t        state;
  hsa_state_t        state_next;
  logic [CW-1:0]     cnt;
  logic [ADDR_W-1:0] rover;
  logic [ADDR_W-1:0] heap_len;
  logic [SW-1:0]     c;
  entry_t            prev;

  // latched command
  func_t             op_func;
  logic [ADDR_W-1:0] op_req;
  logic [ADDR_W-1:0] op_paddr;
  logic              op_alloc;
  logic [ADDR_W:0]   rsize;
  policy_t           policy;

  // search trackers: find, primary candidate, wrapped next-fit candidate
  logic              f_v;
  logic [IW-1:0]     f_idx;
  logic [ADDR_W-1:0] f_size;
  logic              a_v;
  logic [IW-1:0]     a_idx;
  logic [ADDR_W-1:0] a_start;
  logic [ADDR_W-1:0] a_size;
  logic [ADDR_W-1:0] a_nxt;
  logic              b_v;
  logic [IW-1:0]     b_idx;
  logic [ADDR_W-1:0] b_start;
  logic [ADDR_W-1:0] b_size;
  logic [ADDR_W-1:0] b_nxt;

  // plan set up at decision time
  logic [IW-1:0]     sp_idx;
  logic [ADDR_W-1:0] sp_start;
  logic [SW-1:0]     sj;
  logic [IW-1:0]     m1_idx;
  logic [ADDR_W-1:0] m1_start;
  logic              m1_free;
  logic              m2_v;
  logic [IW-1:0]     m2_idx;
  logic [ADDR_W-1:0] m2_start;
  logic              mg;
  logic [CW-1:0]     wptr;
  logic              lkf;

  // result
  status_t           st;
  logic [ADDR_W-1:0] raddr_res;
  logic [ADDR_W-1:0] ub;
  logic [ADDR_W-1:0] fb;

  // table port
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic [IW-1:0]     mem_raddr;
  entry_t            rdata;

  // ---------------------------------------------------------------------------
  // configuration port, register i at byte 4*i
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_bytes  <= ADDR_W'(RST_HEAP_BYTES);
      small_limit <= ADDR_W'(RST_SMALL_LIMIT);
      large_limit <= ADDR_W'(RST_LARGE_LIMIT);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HEAP_BYTES:  heap_bytes  <= pwdata[ADDR_W-1:0];
        REG_SMALL_LIMIT: small_limit <= pwdata[ADDR_W-1:0];
        REG_LARGE_LIMIT: large_limit <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HEAP_BYTES:  prdata = {15'b0, heap_bytes};
      REG_SMALL_LIMIT: prdata = {15'b0, small_limit};
      REG_LARGE_LIMIT: prdata = {15'b0, large_limit};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // command decode at accept
  // ---------------------------------------------------------------------------
  logic              cmd_acc;
  func_t             in_func;
  logic [ADDR_W:0]   in_rsize;
  logic              in_alloc;
  policy_t           in_policy;
  logic [ADDR_W-1:0] hl_cfg;
  logic              hl_fits;

  assign cmd_ready = (state == S_IDLE);
  assign cmd_acc   = cmd_valid && cmd_ready;
  assign in_func   = func_t'(func);
  // round up to the 8-byte grain
  assign in_rsize  = ({1'b0, req_size} + (ADDR_W+1)'(GRAIN - 1)) &
                     ~((ADDR_W+1)'(GRAIN - 1));
  assign in_alloc  = (in_func == FN_ALLOC) ||
                     (in_func == FN_REALLOC && payload_addr == '0);

  always_comb begin
    if (in_rsize < {1'b0, small_limit}) begin
      in_policy = FIT_FIRST;
    end else if (in_rsize > {1'b0, large_limit}) begin
      in_policy = FIT_BEST;
    end else begin
      in_policy = FIT_NEXT;
    end
  end

  // heap length clamped to the build size
  assign hl_cfg  = ({1'b0, heap_bytes} < HEAP_CAP) ? heap_bytes : HEAP_CAP[ADDR_W-1:0];
  assign hl_fits = {1'b0, hl_cfg} > HDR;

  // ---------------------------------------------------------------------------
  // table walk: cycle c reads entry c, block c-2 is evaluated from the
  // previous entry and the start of the one just read
  // ---------------------------------------------------------------------------
  logic [SW-1:0]     cnt_s;
  logic              scan_end;
  logic              ev_on;
  logic [IW-1:0]     b_cur;
  logic [ADDR_W-1:0] nxt_start;
  blk_info_t         info;
  logic [ADDR_W-1:0] acc_sum;

  assign cnt_s     = SW'(cnt);
  assign scan_end  = (c == cnt_s + SW'(1));
  assign ev_on     = (c > SW'(1));
  assign b_cur     = IW'(c - SW'(2));
  assign nxt_start = scan_end ? heap_len : rdata.start;

  hsa_blk_eval #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_eval (
    .cur        (prev),
    .next_start (nxt_start),
    .last       (scan_end),
    .rover      (rover),
    .rsize      (rsize),
    .info       (info)
  );

  // single adder for the totals, steered by the free mark
  assign acc_sum = (prev.free ? fb : ub) + info.size;

  // compaction: a free entry right after a kept free entry is dropped
  logic merge_keep;
  logic merge_on;
  logic merge_end;

  assign merge_keep = !(rdata.free && lkf);
  assign merge_on   = (c != '0);
  assign merge_end  = (c == cnt_s);

  // ---------------------------------------------------------------------------
  // decision after the search walk
  // ---------------------------------------------------------------------------
  logic              h_v;
  logic [IW-1:0]     h_idx;
  logic [ADDR_W-1:0] h_start;
  logic [ADDR_W-1:0] h_size;
  logic [ADDR_W-1:0] h_nxt;
  logic [ADDR_W-1:0] f_start;
  logic              free_path;
  logic              shrink;
  logic              grow;
  logic              commit;
  logic [ADDR_W-1:0] sz_sel;
  logic              split_ok;
  status_t           dec_st;
  logic [ADDR_W-1:0] dec_raddr;

  always_comb begin
    // next fit wraps to the first hit when nothing at or after the rover fits
    if (policy == FIT_NEXT && !a_v) begin
      h_v = b_v; h_idx = b_idx; h_start = b_start; h_size = b_size; h_nxt = b_nxt;
    end else begin
      h_v = a_v; h_idx = a_idx; h_start = a_start; h_size = a_size; h_nxt = a_nxt;
    end
    f_start   = ADDR_W'({1'b0, op_paddr} - HDR);
    free_path = !op_alloc && f_v && (op_func == FN_FREE || op_req == '0);
    shrink    = !op_alloc && f_v && !free_path && (f_size >= op_req);
    grow      = !op_alloc && f_v && !free_path && !shrink;
    commit    = h_v && (op_alloc || grow);
    sz_sel    = shrink ? f_size : h_size;
    split_ok  = (shrink || commit) && (cnt < CNT_MAX) &&
                ({1'b0, sz_sel} >= rsize + HDR + (ADDR_W+1)'(SPLIT_MIN));
    if (op_alloc) begin
      dec_st = h_v ? ST_OK : ST_NOFIT;
    end else if (!f_v) begin
      dec_st = ST_BADADDR;
    end else if (free_path || shrink) begin
      dec_st = ST_OK;
    end else begin
      dec_st = h_v ? ST_OK : ST_NOFIT;
    end
    if (commit) begin
      dec_raddr = ADDR_W'({1'b0, h_start} + HDR);
    end else if (shrink) begin
      dec_raddr = op_paddr;
    end else begin
      dec_raddr = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state and table port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '{start: '0, free: 1'b1};
    mem_raddr  = c[IW-1:0];
    case (state)
      S_CLEAR: begin
        mem_we     = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_acc) begin
          if (in_func == FN_REINIT) begin
            state_next = S_REINIT;
          end else if (cnt == '0) begin
            state_next = S_TOTAL;
          end else if (in_alloc) begin
            state_next = (in_rsize == '0) ? S_TOTAL : S_SCAN;
          end else if (payload_addr == '0) begin
            state_next = S_TOTAL;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_REINIT: begin
        mem_we     = 1'b1;
        state_next = S_TOTAL;
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (commit || shrink) begin
          state_next = split_ok ? S_SHIFT_RD : S_MARK1;
        end else if (free_path) begin
          state_next = S_MARK1;
        end else begin
          state_next = S_TOTAL;
        end
      end
      S_SHIFT_RD: begin
        mem_raddr = IW'(sj - SW'(1));
        if (sj >= SW'(sp_idx) + SW'(2)) begin
          state_next = S_SHIFT_WR;
        end else begin
          state_next = S_SPLIT_WR;
        end
      end
      S_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = sj[IW-1:0];
        mem_wdata  = rdata;
        state_next = S_SHIFT_RD;
      end
      S_SPLIT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = sp_idx + IW'(1);
        mem_wdata  = '{start: ADDR_W'({1'b0, sp_start} + HDR + rsize), free: 1'b1};
        state_next = S_MARK1;
      end
      S_MARK1: begin
        mem_we     = 1'b1;
        mem_waddr  = m1_idx;
        mem_wdata  = '{start: m1_start, free: m1_free};
        if (m2_v) begin
          state_next = S_MARK2;
        end else if (mg) begin
          state_next = S_MERGE;
        end else begin
          state_next = S_TOTAL;
        end
      end
      S_MARK2: begin
        mem_we     = 1'b1;
        mem_waddr  = m2_idx;
        mem_wdata  = '{start: m2_start, free: 1'b1};
        state_next = S_MERGE;
      end
      S_MERGE: begin
        mem_we    = merge_on && merge_keep;
        mem_waddr = wptr[IW-1:0];
        mem_wdata = rdata;
        if (merge_end) begin
          state_next = S_TOTAL;
        end
      end
      S_TOTAL: begin
        if (scan_end) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  hsa_table #(
    .DEPTH (MAX_BLOCKS),
    .IW    (IW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= RST_CNT;
      rover    <= '0;
      heap_len <= RST_LEN;
      c        <= '0;
    end else begin
      // walk counter restarts on every state change
      if (state_next != state) begin
        c <= '0;
      end else begin
        c <= c + SW'(1);
      end
      case (state)
        S_REINIT: begin
          heap_len <= hl_cfg;
          cnt      <= hl_fits ? CW'(1) : CW'(0);
          rover    <= '0;
        end
        S_DECIDE: begin
          if (commit && policy == FIT_NEXT) begin
            rover <= h_nxt;
          end
        end
        S_SPLIT_WR: begin
          cnt <= cnt + CW'(1);
        end
        S_MERGE: begin
          if (merge_end) begin
            cnt <= wptr + CW'(merge_keep);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prev <= rdata;
    // totals start from zero on entry to the totals walk
    if (state_next == S_TOTAL && state != S_TOTAL) begin
      ub <= '0;
      fb <= '0;
    end
    // compaction pointers start from zero on entry to the merge pass
    if (state_next == S_MERGE && state != S_MERGE) begin
      wptr <= '0;
      lkf  <= 1'b0;
    end
    case (state)
      S_IDLE: begin
        op_func   <= in_func;
        op_req    <= req_size;
        op_paddr  <= payload_addr;
        op_alloc  <= in_alloc;
        rsize     <= in_rsize;
        policy    <= in_policy;
        f_v       <= 1'b0;
        a_v       <= 1'b0;
        b_v       <= 1'b0;
        raddr_res <= '0;
        st        <= (cnt == '0 && in_func != FN_REINIT) ? ST_NOINIT : ST_OK;
      end
      S_REINIT: begin
        st <= hl_fits ? ST_OK : ST_NOINIT;
      end
      S_SCAN: begin
        if (ev_on) begin
          if (!f_v && !prev.free && info.pay == {1'b0, op_paddr}) begin
            f_v    <= 1'b1;
            f_idx  <= b_cur;
            f_size <= info.size;
          end
          if (info.fits) begin
            if ((policy == FIT_FIRST && !a_v) ||
                (policy == FIT_BEST && (!a_v || info.size < a_size)) ||
                (policy == FIT_NEXT && info.ge_r && !a_v)) begin
              a_v     <= 1'b1;
              a_idx   <= b_cur;
              a_start <= prev.start;
              a_size  <= info.size;
              a_nxt   <= scan_end ? '0 : rdata.start;
            end
            if (policy == FIT_NEXT && !b_v) begin
              b_v     <= 1'b1;
              b_idx   <= b_cur;
              b_start <= prev.start;
              b_size  <= info.size;
              b_nxt   <= scan_end ? '0 : rdata.start;
            end
          end
        end
      end
      S_DECIDE: begin
        st        <= dec_st;
        raddr_res <= dec_raddr;
        sp_idx    <= shrink ? f_idx : h_idx;
        sp_start  <= shrink ? f_start : h_start;
        sj        <= cnt_s;
        m1_idx    <= commit ? h_idx : f_idx;
        m1_start  <= commit ? h_start : f_start;
        m1_free   <= free_path;
        m2_v      <= grow && h_v;
        m2_idx    <= f_idx + IW'(split_ok && (h_idx < f_idx));
        m2_start  <= f_start;
        mg        <= free_path || (grow && h_v);
      end
      S_SHIFT_WR: begin
        sj <= sj - SW'(1);
      end
      S_MERGE: begin
        if (merge_on && merge_keep) begin
          wptr <= wptr + CW'(1);
          lkf  <= rdata.free;
        end
      end
      S_TOTAL: begin
        if (ev_on) begin
          if (prev.free) begin
            fb <= acc_sum;
          end else begin
            ub <= acc_sum;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // response register, loaded when the previous beat has gone
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_OUT && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!rsp_valid || rsp_ready)) begin
      status      <= st;
      result_addr <= raddr_res;
      used_bytes  <= ub;
      free_bytes  <= fb;
    end
  end

endmodule

// ===== hw/rtl/hsa_checker.sv =====
// ----------------------------------------------------------------------------
// hsa_checker
// port-level checks on the heap segment allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "heap_segment_allocator_assert.svh"

module hsa_checker import hsa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [16:0] result_addr,
  input logic [16:0] used_bytes
);

  // a pending response beat stays up
  `HSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

  // one command at a time: busy right after a beat is taken
  `HSA_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && cmd_ready, !cmd_ready)

  // a failed request grants nothing
  `HSA_ASSERT_NOW(a_fail_null, rsp_valid && status != ST_OK, result_addr == '0)

  // a granted block shows up in the used total
  `HSA_ASSERT_NOW(a_grant_used, rsp_valid && status == ST_OK && result_addr != '0,
                  used_bytes != '0)

endmodule

bind heap_segment_allocator hsa_checker u_hsa_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd_valid),
  .cmd_ready   (cmd_ready),
  .rsp_valid   (rsp_valid),
  .rsp_ready   (rsp_ready),
  .status      (status),
  .result_addr (result_addr),
  .used_bytes  (used_bytes)
);
